FILE: hw/rtl/thrpct_pkg.sv
// ----------------------------------------------------------------------------
// thrpct_pkg
// Shared types and constants of the throttle sample to percent core.
// ----------------------------------------------------------------------------
package thrpct_pkg;

   localparam int SAMPLE_W    = 8;
   localparam int SAMPLE_CNT  = 4;
   localparam int SUM_W       = SAMPLE_W + $clog2(SAMPLE_CNT);
   localparam int SAMPLE_SHIFT = $clog2(SAMPLE_CNT);
   localparam int TIME_W      = 32;
   localparam int MV_W        = 13;
   localparam int CODE_SHIFT  = 8;              // divide by 256
   localparam int PROD_W      = SAMPLE_W + MV_W;
   localparam int PCT_W       = 7;
   localparam int PCT_MUL_W   = 7;
   localparam int DIVIDEND_W  = MV_W + PCT_MUL_W - 1;   // 5000 * 100 fits 19 bits
   localparam int DIV_STEP_W  = $clog2(PCT_W);

   localparam logic [MV_W-1:0]      FULL_SCALE_MV = MV_W'(5000);
   localparam logic [MV_W-1:0]      HARD_LOW_MV   = MV_W'(500);
   localparam logic [MV_W-1:0]      HARD_HIGH_MV  = MV_W'(4500);
   localparam logic [TIME_W-1:0]    TOLERANCE_MS  = TIME_W'(1000);
   localparam logic [PCT_MUL_W-1:0] PERCENT_TOP   = PCT_MUL_W'(100);

   localparam logic [MV_W-1:0] MIN_MV_RESET = MV_W'(0);
   localparam logic [MV_W-1:0] MAX_MV_RESET = MV_W'(5000);

   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_IDX_W  = 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_MV = 1'b0,
      CSR_MAX_MV = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_EVAL,
      ST_START,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic             done;
      logic [PCT_W-1:0] quotient;
   } div_status_type;

endpackage

FILE: hw/rtl/thrpct_div.sv
// ----------------------------------------------------------------------------
// thrpct_div
// Restoring divider, one quotient bit per cycle, for quotients below 128.
// ----------------------------------------------------------------------------
module thrpct_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [thrpct_pkg::DIVIDEND_W-1:0]   dividend,
   input  logic [thrpct_pkg::MV_W-1:0]         divisor,
   output thrpct_pkg::div_status_type          status
);

   localparam int SH_W = thrpct_pkg::MV_W + thrpct_pkg::PCT_W - 1;

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [thrpct_pkg::DIV_STEP_W-1:0]   cnt_ff, cnt_in;
   logic [thrpct_pkg::DIVIDEND_W-1:0]   rem_ff, rem_in;
   logic [SH_W-1:0]                     dsh_ff, dsh_in;
   logic [thrpct_pkg::PCT_W-1:0]        quo_ff, quo_in;
   logic                                fits;

   assign fits = {1'b0, rem_ff} >= {1'b0, dsh_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = thrpct_pkg::DIV_STEP_W'(thrpct_pkg::PCT_W - 1);
         rem_in  = dividend;
         dsh_in  = SH_W'(divisor) << (thrpct_pkg::PCT_W - 1);
         quo_in  = '0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - dsh_ff;
         end
         quo_in = {quo_ff[thrpct_pkg::PCT_W-2:0], fits};
         dsh_in = dsh_ff >> 1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
   end

   assign status.done     = done_ff;
   assign status.quotient = quo_ff;

endmodule

FILE: hw/rtl/throttle_sample_to_percent_core.sv
// ----------------------------------------------------------------------------
// throttle_sample_to_percent_core
// Turns four converter samples into a throttle demand in percent.
// ----------------------------------------------------------------------------
// Each request item carries four 8-bit samples and a millisecond timestamp.
// The core averages the samples, scales them to millivolts (x5000/256),
// substitutes the last in-range reading when outside 500..4500 mV, raises a
// range fault after more than 1000 ms out of range, and maps the voltage
// between the min and max registers to 0..100 percent. A new item is accepted
// only in the idle state, after the previous item has left the sequencer; the
// bit-serial divider forms the percent value. When the demand is forced to
// zero (reading below min, or max not above min) the divider is skipped. The
// result sits in an output register, so a new item is accepted while the
// previous result still waits on rsp_tready; a second result then holds the
// core in its last step until the output register is taken. Registers are
// written through csr_we / csr_index / csr_wdata and must only change while
// the core is idle.
// ----------------------------------------------------------------------------
module throttle_sample_to_percent_core (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: sample_a[7:0], sample_b[15:8], sample_c[23:16],
   //            sample_d[31:24], now_ms[63:32]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [thrpct_pkg::REQ_DATA_W-1:0]   req_tdata,
   // rsp_tdata: percent[6:0], used_millivolts[19:7], range_ok[20],
   //            low_seen[21], zero fill[23:22]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [thrpct_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                                csr_we,
   input  logic [thrpct_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [thrpct_pkg::MV_W-1:0]         csr_wdata
);

   localparam int SW = thrpct_pkg::SAMPLE_W;
   localparam int MW = thrpct_pkg::MV_W;
   localparam int TW = thrpct_pkg::TIME_W;
   localparam int PW = thrpct_pkg::PCT_W;

   thrpct_pkg::state_type state_ff, state_in;

   // configuration
   logic [MW-1:0] min_mv_ff, max_mv_ff;

   // per-item working registers
   logic [SW-1:0] avg_ff, avg_in;
   logic [TW-1:0] now_ff, now_in;
   logic [MW-1:0] mv_ff, mv_in;
   logic [MW-1:0] used_ff, used_in;
   logic [MW-1:0] diff_ff, diff_in;
   logic [MW-1:0] span_ff, span_in;
   logic          pct_zero_ff, pct_zero_in;

   // persistent state
   logic [MW-1:0] held_ff, held_in;
   logic [TW-1:0] fault_ff, fault_in;
   logic          good_ff, good_in;
   logic          low_ff, low_in;

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0] out_pct_ff, out_pct_in;
   logic [MW-1:0] out_used_ff, out_used_in;
   logic          out_ok_ff, out_ok_in;
   logic          out_low_ff, out_low_in;

   logic [thrpct_pkg::SUM_W-1:0]      sum;
   logic [thrpct_pkg::PROD_W-1:0]     prod;
   logic [thrpct_pkg::DIVIDEND_W-1:0] dividend;
   logic                              out_of_range;
   logic [MW-1:0]                     used_w, clamp_w;
   logic [TW-1:0]                     elapsed;
   logic                              div_start;
   logic                              out_free;
   thrpct_pkg::div_status_type        div_status;

   assign sum = thrpct_pkg::SUM_W'(req_tdata[SW-1:0])
              + thrpct_pkg::SUM_W'(req_tdata[2*SW-1:SW])
              + thrpct_pkg::SUM_W'(req_tdata[3*SW-1:2*SW])
              + thrpct_pkg::SUM_W'(req_tdata[4*SW-1:3*SW]);

   assign prod = thrpct_pkg::PROD_W'(avg_ff)
               * thrpct_pkg::PROD_W'(thrpct_pkg::FULL_SCALE_MV);

   assign out_of_range = (mv_ff < thrpct_pkg::HARD_LOW_MV)
                      || (mv_ff > thrpct_pkg::HARD_HIGH_MV);
   assign used_w  = out_of_range ? held_ff : mv_ff;
   assign clamp_w = (used_w > max_mv_ff) ? max_mv_ff : used_w;
   assign elapsed = now_ff - fault_ff;

   assign dividend = thrpct_pkg::DIVIDEND_W'(diff_ff)
                   * thrpct_pkg::DIVIDEND_W'(thrpct_pkg::PERCENT_TOP);

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == thrpct_pkg::ST_IDLE);

   thrpct_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (span_ff),
      .status   (div_status)
   );

   // sequencer and datapath
   always_comb begin
      state_in     = state_ff;
      avg_in       = avg_ff;
      now_in       = now_ff;
      mv_in        = mv_ff;
      used_in      = used_ff;
      diff_in      = diff_ff;
      span_in      = span_ff;
      pct_zero_in  = pct_zero_ff;
      held_in      = held_ff;
      fault_in     = fault_ff;
      good_in      = good_ff;
      low_in       = low_ff;
      div_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      out_pct_in   = out_pct_ff;
      out_used_in  = out_used_ff;
      out_ok_in    = out_ok_ff;
      out_low_in   = out_low_ff;

      unique case (state_ff)
         thrpct_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               // average with truncation: drop the two low bits of the sum
               avg_in   = sum[thrpct_pkg::SUM_W-1:thrpct_pkg::SAMPLE_SHIFT];
               now_in   = req_tdata[thrpct_pkg::REQ_DATA_W-1:4*SW];
               state_in = thrpct_pkg::ST_SCALE;
            end
         end
         thrpct_pkg::ST_SCALE: begin
            // scale to millivolts: x5000 then drop eight bits
            mv_in    = prod[thrpct_pkg::PROD_W-1:thrpct_pkg::CODE_SHIFT];
            state_in = thrpct_pkg::ST_EVAL;
         end
         thrpct_pkg::ST_EVAL: begin
            if (out_of_range) begin
               // fault timer: zero means not armed, elapsed time wraps
               if (fault_ff != '0) begin
                  if (good_ff && (elapsed > thrpct_pkg::TOLERANCE_MS)) begin
                     good_in = 1'b0;
                  end
               end else begin
                  fault_in = now_ff;
               end
            end else begin
               fault_in = '0;
               good_in  = 1'b1;
               held_in  = mv_ff;
            end
            used_in = used_w;
            diff_in = clamp_w - min_mv_ff;
            span_in = max_mv_ff - min_mv_ff;
            if (used_w < min_mv_ff) begin
               low_in      = 1'b1;
               pct_zero_in = 1'b1;
            end else begin
               pct_zero_in = !(max_mv_ff > min_mv_ff);
            end
            state_in = pct_zero_in ? thrpct_pkg::ST_DONE : thrpct_pkg::ST_START;
         end
         thrpct_pkg::ST_START: begin
            div_start = 1'b1;
            state_in  = thrpct_pkg::ST_DIVIDE;
         end
         thrpct_pkg::ST_DIVIDE: begin
            if (div_status.done) begin
               state_in = thrpct_pkg::ST_DONE;
            end
         end
         thrpct_pkg::ST_DONE: begin
            // hold until the output register is free, then load it
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_pct_in   = pct_zero_ff ? '0 : div_status.quotient;
               out_used_in  = used_ff;
               out_ok_in    = good_ff;
               out_low_in   = low_ff;
               state_in     = thrpct_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = thrpct_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= thrpct_pkg::ST_IDLE;
         held_ff      <= '0;
         fault_ff     <= '0;
         good_ff      <= 1'b1;
         low_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         fault_ff     <= fault_in;
         good_ff      <= good_in;
         low_ff       <= low_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      avg_ff      <= avg_in;
      now_ff      <= now_in;
      mv_ff       <= mv_in;
      used_ff     <= used_in;
      diff_ff     <= diff_in;
      span_ff     <= span_in;
      pct_zero_ff <= pct_zero_in;
      out_pct_ff  <= out_pct_in;
      out_used_ff <= out_used_in;
      out_ok_ff   <= out_ok_in;
      out_low_ff  <= out_low_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_mv_ff <= thrpct_pkg::MIN_MV_RESET;
         max_mv_ff <= thrpct_pkg::MAX_MV_RESET;
      end else if (csr_we) begin
         unique case (thrpct_pkg::csr_index_type'(csr_index))
            thrpct_pkg::CSR_MIN_MV: min_mv_ff <= csr_wdata;
            thrpct_pkg::CSR_MAX_MV: max_mv_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, out_low_ff, out_ok_ff, out_used_ff, out_pct_ff};

endmodule
